// ----- hdl/pip_pkg.sv -----
// Shared constants, types and codes for the point-in-polygon crossing-number unit.
// No dependencies; every other file in the hdl folder refers to it by scoped names.
package pip_pkg;

    // Coordinate width and the widths that follow from it.
    localparam int COORD_WIDTH   = 16;
    localparam int DY_WIDTH      = COORD_WIDTH + 1;
    localparam int PROD_WIDTH    = 2 * COORD_WIDTH + 1;
    localparam int NUM_WIDTH     = 2 * COORD_WIDTH + 2;
    localparam int DIV_CNT_WIDTH = $clog2(NUM_WIDTH);
    localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(NUM_WIDTH - 1);

    // Vertex count, saturating at three.
    localparam int SEEN_WIDTH = 2;
    localparam logic [SEEN_WIDTH-1:0] SEEN_NONE = 2'd0;
    localparam logic [SEEN_WIDTH-1:0] SEEN_ONE  = 2'd1;
    localparam logic [SEEN_WIDTH-1:0] SEEN_TWO  = 2'd2;
    localparam logic [SEEN_WIDTH-1:0] SEEN_MAX  = 2'd3;

    // Which edge the datapath is working on.
    typedef enum logic {
        EDGE_BODY,   // previous vertex to current vertex
        EDGE_CLOSE   // current vertex back to the first vertex
    } t_edge;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_SUB,
        ST_DIV,
        ST_APPLY,
        ST_NEXT,
        ST_COMMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        t_edge edge_sel;
        logic  mul_en;
        logic  sub_en;
        logic  div_step;
        logic  apply;
        logic  commit;
        logic  emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic restart;
        logic close_needed;
        logic edge_live;
        logic div_last;
        logic out_busy;
    } t_sts;

endpackage

// ----- hdl/pip_if.sv -----
// Valid/ready channel interfaces for the vertex input and the result output.
// Depends on pip_pkg for the coordinate width.
interface pip_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pip_pkg::COORD_WIDTH-1:0] query_x;
    logic signed [pip_pkg::COORD_WIDTH-1:0] query_y;
    logic signed [pip_pkg::COORD_WIDTH-1:0] vertex_x;
    logic signed [pip_pkg::COORD_WIDTH-1:0] vertex_y;
    logic                                 first_vertex;
    logic                                 last_vertex;

    modport source (
        output valid, query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex,
        output ready
    );
endinterface

interface pip_out_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, inside_res, input ready);
    modport sink (input valid, inside_res, output ready);
endinterface

// ----- hdl/pip_ctrl.sv -----
// Controller state machine: sequences load, edge tests, division and commit for each item.
// Depends on pip_pkg for the state, command and status types.
module pip_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pip_pkg::t_sts  i_sts,
    output pip_pkg::t_cmd  o_cmd
);

    pip_pkg::t_state r_state, n_state;
    pip_pkg::t_edge  r_edge, n_edge;

    // State and edge-select registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pip_pkg::ST_IDLE;
            r_edge  <= pip_pkg::EDGE_BODY;
        end else begin
            r_state <= n_state;
            r_edge  <= n_edge;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state        = r_state;
        n_edge         = r_edge;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.edge_sel = r_edge;
        case (r_state)
            pip_pkg::ST_IDLE: begin
                // No item is taken while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = pip_pkg::ST_DECIDE;
                end
            end
            pip_pkg::ST_DECIDE: begin
                n_edge = pip_pkg::EDGE_BODY;
                if (i_sts.restart) begin
                    n_state = pip_pkg::ST_COMMIT;
                end else begin
                    n_state = pip_pkg::ST_MUL;
                end
            end
            pip_pkg::ST_MUL: begin
                if (i_sts.edge_live) begin
                    o_cmd.mul_en = 1'b1;
                    n_state      = pip_pkg::ST_SUB;
                end else begin
                    n_state = pip_pkg::ST_NEXT;
                end
            end
            pip_pkg::ST_SUB: begin
                o_cmd.sub_en = 1'b1;
                n_state      = pip_pkg::ST_DIV;
            end
            pip_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = pip_pkg::ST_APPLY;
                end
            end
            pip_pkg::ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = pip_pkg::ST_NEXT;
            end
            pip_pkg::ST_NEXT: begin
                if (r_edge == pip_pkg::EDGE_BODY && i_sts.close_needed) begin
                    n_edge  = pip_pkg::EDGE_CLOSE;
                    n_state = pip_pkg::ST_MUL;
                end else begin
                    n_state = pip_pkg::ST_COMMIT;
                end
            end
            pip_pkg::ST_COMMIT: begin
                // A closing item waits here until the result register can take it.
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.emit   = 1'b1;
                    n_state      = pip_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pip_pkg::ST_IDLE;
            end
        endcase
    end

    // A result is only written into a free or draining result register.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_sts.out_busy)
        else $error("result emitted while output register is held");

    // A vertex that restarts a polygon goes straight to commit without any edge test.
    a_restart_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pip_pkg::ST_DECIDE && i_sts.restart) |=> r_state == pip_pkg::ST_COMMIT)
        else $error("restart vertex entered an edge test");

    // The divider runs only for the edge that was just multiplied.
    a_div_after_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_cmd.div_step) |-> $past(o_cmd.sub_en))
        else $error("division started without a fresh operand load");

endmodule

// ----- hdl/pip_datapath.sv -----
// Datapath: polygon state, edge multipliers, iterative divider, parities and result register.
// Depends on pip_pkg for widths and the command and status types.
module pip_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] i_query_x,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] i_query_y,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] i_vertex_x,
    input  logic signed [pip_pkg::COORD_WIDTH-1:0] i_vertex_y,
    input  logic                                   i_first_vertex,
    input  logic                                   i_last_vertex,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic                                   o_inside_res,
    input  pip_pkg::t_cmd                          i_cmd,
    output pip_pkg::t_sts                          o_sts
);

    // Latched item.
    logic signed [pip_pkg::COORD_WIDTH-1:0] r_qx, r_qy, r_vx, r_vy;
    logic                                   r_first, r_last;

    // Polygon state.
    logic signed [pip_pkg::COORD_WIDTH-1:0] r_start_x, r_start_y, r_prior_x, r_prior_y;
    logic [pip_pkg::SEEN_WIDTH-1:0]         r_seen;
    logic                                   r_left_odd, r_right_odd;

    // Edge arithmetic.
    logic signed [pip_pkg::PROD_WIDTH-1:0]  r_p1, r_p2;
    logic signed [pip_pkg::DY_WIDTH-1:0]    r_dy;
    logic [pip_pkg::NUM_WIDTH-1:0]          r_quo;
    logic [pip_pkg::DY_WIDTH-1:0]           r_rem, r_den;
    logic                                   r_neg;
    logic [pip_pkg::DIV_CNT_WIDTH-1:0]      r_cnt;

    // Result register.
    logic r_out_valid, r_out_inside;

    logic signed [pip_pkg::COORD_WIDTH-1:0] x1, y1, x2, y2;
    logic signed [pip_pkg::DY_WIDTH-1:0]    dy1, dy2;
    logic signed [pip_pkg::NUM_WIDTH-1:0]   num;
    logic [pip_pkg::NUM_WIDTH-1:0]          num_mag;
    logic [pip_pkg::DY_WIDTH-1:0]           den_mag;
    logic [pip_pkg::DY_WIDTH:0]             rem_shift, rem_diff;
    logic [pip_pkg::COORD_WIDTH:0]          quo_mag;
    logic signed [pip_pkg::COORD_WIDTH+1:0] cross_x, qx_ext;
    logic                                   restart, close_needed;

    // Edge operand selection: body edge runs prior to current, closing edge current to first.
    always_comb begin
        if (i_cmd.edge_sel == pip_pkg::EDGE_CLOSE) begin
            x1 = r_vx;
            y1 = r_vy;
            x2 = r_start_x;
            y2 = r_start_y;
        end else begin
            x1 = r_prior_x;
            y1 = r_prior_y;
            x2 = r_vx;
            y2 = r_vy;
        end
        dy1 = pip_pkg::DY_WIDTH'(y1) - pip_pkg::DY_WIDTH'(r_qy);
        dy2 = pip_pkg::DY_WIDTH'(y2) - pip_pkg::DY_WIDTH'(r_qy);
    end

    // Item classification.
    assign restart      = r_first || (r_seen == pip_pkg::SEEN_NONE);
    assign close_needed = r_last && !restart && (r_seen >= pip_pkg::SEEN_TWO);

    // Numerator of the crossing quotient and magnitudes for the unsigned divider.
    always_comb begin
        num     = pip_pkg::NUM_WIDTH'(r_p1) - pip_pkg::NUM_WIDTH'(r_p2);
        num_mag = num[pip_pkg::NUM_WIDTH-1] ? pip_pkg::NUM_WIDTH'(-num)
                                            : pip_pkg::NUM_WIDTH'(num);
        den_mag = r_dy[pip_pkg::DY_WIDTH-1] ? pip_pkg::DY_WIDTH'(-r_dy)
                                            : pip_pkg::DY_WIDTH'(r_dy);
    end

    // One restoring division step.
    always_comb begin
        rem_shift = {r_rem, r_quo[pip_pkg::NUM_WIDTH-1]};
        rem_diff  = rem_shift - {1'b0, r_den};
    end

    // Truncated crossing x, compared with the query x.
    always_comb begin
        quo_mag = r_quo[pip_pkg::COORD_WIDTH:0];
        cross_x = r_neg ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});
        qx_ext  = (pip_pkg::COORD_WIDTH + 2)'(r_qx);
    end

    // Item latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_qx    <= i_query_x;
            r_qy    <= i_query_y;
            r_vx    <= i_vertex_x;
            r_vy    <= i_vertex_y;
            r_first <= i_first_vertex;
            r_last  <= i_last_vertex;
        end
    end

    // Products and edge height, registered after the multipliers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_p1 <= x1 * dy2;
            r_p2 <= x2 * dy1;
            r_dy <= pip_pkg::DY_WIDTH'(y2) - pip_pkg::DY_WIDTH'(y1);
        end
    end

    // Iterative divider: loaded with magnitudes, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sub_en) begin
            r_quo <= num_mag;
            r_rem <= '0;
            r_den <= den_mag;
            r_neg <= num[pip_pkg::NUM_WIDTH-1] ^ r_dy[pip_pkg::DY_WIDTH-1];
        end else if (i_cmd.div_step) begin
            if (!rem_diff[pip_pkg::DY_WIDTH]) begin
                r_rem <= rem_diff[pip_pkg::DY_WIDTH-1:0];
                r_quo <= {r_quo[pip_pkg::NUM_WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= rem_shift[pip_pkg::DY_WIDTH-1:0];
                r_quo <= {r_quo[pip_pkg::NUM_WIDTH-2:0], 1'b0};
            end
        end
    end

    // Step counter of the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.sub_en) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Polygon state and crossing parities.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_prior_x   <= '0;
            r_prior_y   <= '0;
            r_seen      <= pip_pkg::SEEN_NONE;
            r_left_odd  <= 1'b0;
            r_right_odd <= 1'b0;
        end else if (i_cmd.apply) begin
            if (cross_x < qx_ext) begin
                r_left_odd <= ~r_left_odd;
            end
            if (cross_x > qx_ext) begin
                r_right_odd <= ~r_right_odd;
            end
        end else if (i_cmd.commit) begin
            r_prior_x <= r_vx;
            r_prior_y <= r_vy;
            if (restart) begin
                r_left_odd  <= 1'b0;
                r_right_odd <= 1'b0;
                r_start_x   <= r_vx;
                r_start_y   <= r_vy;
            end
            if (r_last) begin
                r_seen <= pip_pkg::SEEN_NONE;
            end else if (restart) begin
                r_seen <= pip_pkg::SEEN_ONE;
            end else if (r_seen != pip_pkg::SEEN_MAX) begin
                r_seen <= r_seen + 1'b1;
            end
        end
    end

    // Result register: filled by a closing item, emptied when the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && r_last) begin
            r_out_inside <= close_needed && r_left_odd && r_right_odd;
        end
    end

    // Status to the controller; only a closing item has to wait for the result register.
    always_comb begin
        o_sts.restart      = restart;
        o_sts.close_needed = close_needed;
        o_sts.edge_live    = (y1 != y2) && ((y1 >= r_qy && y2 <= r_qy) ||
                                            (y2 >= r_qy && y1 <= r_qy));
        o_sts.div_last     = (r_cnt == pip_pkg::DIV_LAST);
        o_sts.out_busy     = r_out_valid && !i_out_ready && r_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_inside;

    // The crossing lies between the edge's end points, so its magnitude fits a coordinate.
    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply |-> r_quo[pip_pkg::NUM_WIDTH-1:pip_pkg::COORD_WIDTH+1] == '0)
        else $error("crossing quotient out of coordinate range");

    // Only non-horizontal edges reach the divider.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_den != '0)
        else $error("divider stepping with a zero divisor");

    // A closing item always leaves the vertex count at zero.
    a_seen_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_last) |=> r_seen == pip_pkg::SEEN_NONE)
        else $error("vertex count not cleared after last vertex");

endmodule

// ----- hdl/point_in_polygon_ray_cast_unit.sv -----
// Top level of the point-in-polygon crossing-number unit: controller plus datapath.
// Depends on pip_pkg, pip_in_if, pip_out_if, pip_ctrl and pip_datapath.
//
//   Channel  Dir  Interface    Payload
//   i_in     in   pip_in_if    query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex
//   o_res    out  pip_out_if   inside_res (only after an item with last_vertex set)
//
// A vertex that opens a polygon goes straight to commit; each other vertex tests its edge with
// the multiply, load, divide and apply steps, skipped when the edge is horizontal or misses the
// query row, and a last vertex that is at least the third also tests the closing edge. Each
// live edge test uses the shared restoring divider, one quotient bit per cycle over 34 bits.
// Reset is synchronous and active low; it clears the polygon state and the result register.
// A waiting result does not stop the next vertex being taken; only a second result stalls
// in its commit step until the first has been taken.
module point_in_polygon_ray_cast_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pip_in_if.sink    i_in,
    pip_out_if.source o_res
);

    pip_pkg::t_cmd cmd;
    pip_pkg::t_sts sts;

    pip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pip_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_query_x      (i_in.query_x),
        .i_query_y      (i_in.query_y),
        .i_vertex_x     (i_in.vertex_x),
        .i_vertex_y     (i_in.vertex_y),
        .i_first_vertex (i_in.first_vertex),
        .i_last_vertex  (i_in.last_vertex),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_inside_res   (o_res.inside_res),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule
